/* src/bc12_pkg.sv */
`timescale 1ns / 1ps

package bc12_pkg;

    localparam int unsigned PixCount = 16;
    localparam int unsigned PixIdxW  = 4;

    // x / 3 for x <= 765 as (x * 683) >> 11
    localparam logic [9:0] Div3Mult  = 10'd683;
    localparam int unsigned Div3Shift = 11;

    localparam logic [7:0] AlphaOpaque = 8'hff;
    localparam logic [7:0] AlphaClear  = 8'h00;

    localparam logic [1:0] SelTransp = 2'd3;

    typedef struct packed {
        logic [63:0] color_bits;
        logic [63:0] alpha_bits;
    } in_item_t;

    typedef struct packed {
        logic [PixIdxW-1:0] pixel_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               last;
    } out_item_t;

    typedef logic [7:0] chan_t;

    // one color per palette entry, channels red, green, blue
    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

    // decoded block handed to the pixel sequencer
    typedef struct packed {
        rgb_t [3:0]  pal;
        logic        four;
        logic        mode;
        logic [31:0] sel;
        logic [63:0] alpha_bits;
    } blk_t;

endpackage

/* src/bc12_palette.sv */
`timescale 1ns / 1ps

module bc12_palette (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               mode,
    input  logic               in_valid,
    output logic               in_ready,
    input  bc12_pkg::in_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output bc12_pkg::blk_t     out_blk
);

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [9:0] t2;
        logic [9:0] t3;
    } chan_sum_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        widen6 = {v, v[5:4]};
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = x * bc12_pkg::Div3Mult;
        div3 = prod[bc12_pkg::Div3Shift +: 8];
    endfunction

    // stage 1: widened endpoints and weighted sums
    logic            v1_reg;
    logic            v1_next;
    chan_sum_t [2:0] sum1_reg;
    logic            four1_reg;
    logic            mode1_reg;
    logic [31:0]     sel1_reg;
    logic [63:0]     abits1_reg;

    // stage 2: full palette
    logic            v2_reg;
    logic            v2_next;
    bc12_pkg::blk_t  blk2_reg;

    logic            adv1;
    logic            adv2;

    logic [15:0]     ep0;
    logic [15:0]     ep1;
    logic            four;
    logic [7:0]      c0 [3];
    logic [7:0]      c1 [3];
    chan_sum_t [2:0] sum_next;
    bc12_pkg::blk_t  blk_next;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign ep0  = in_item.color_bits[15:0];
    assign ep1  = in_item.color_bits[31:16];
    assign four = mode || (ep0 > ep1);

    always_comb begin
        c0[0] = widen5(ep0[15:11]);
        c0[1] = widen6(ep0[10:5]);
        c0[2] = widen5(ep0[4:0]);
        c1[0] = widen5(ep1[15:11]);
        c1[1] = widen6(ep1[10:5]);
        c1[2] = widen5(ep1[4:0]);
        for (int c = 0; c < 3; c++) begin
            sum_next[c].c0 = c0[c];
            sum_next[c].c1 = c1[c];
            if (four) begin
                sum_next[c].t2 = {c0[c], 1'b0} + {2'b00, c1[c]};
                sum_next[c].t3 = {2'b00, c0[c]} + {c1[c], 1'b0};
            end else begin
                sum_next[c].t2 = {2'b00, c0[c]} + {2'b00, c1[c]};
                sum_next[c].t3 = '0;
            end
        end
    end

    // channel 0 is red, 1 green, 2 blue
    always_comb begin
        logic [7:0] p2 [3];
        logic [7:0] p3 [3];
        for (int c = 0; c < 3; c++) begin
            p2[c] = four1_reg ? div3(sum1_reg[c].t2) : sum1_reg[c].t2[8:1];
            p3[c] = four1_reg ? div3(sum1_reg[c].t3) : 8'd0;
        end
        blk_next.pal[0]     = '{r: sum1_reg[0].c0, g: sum1_reg[1].c0, b: sum1_reg[2].c0};
        blk_next.pal[1]     = '{r: sum1_reg[0].c1, g: sum1_reg[1].c1, b: sum1_reg[2].c1};
        blk_next.pal[2]     = '{r: p2[0], g: p2[1], b: p2[2]};
        blk_next.pal[3]     = '{r: p3[0], g: p3[1], b: p3[2]};
        blk_next.four       = four1_reg;
        blk_next.mode       = mode1_reg;
        blk_next.sel        = sel1_reg;
        blk_next.alpha_bits = abits1_reg;
    end

    assign v1_next = adv1 ? in_valid : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            sum1_reg   <= sum_next;
            four1_reg  <= four;
            mode1_reg  <= mode;
            sel1_reg   <= in_item.color_bits[63:32];
            abits1_reg <= in_item.alpha_bits;
        end
        if (adv2 && v1_reg) begin
            blk2_reg <= blk_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_blk   = blk2_reg;

endmodule

/* src/bc12_pixel_seq.sv */
`timescale 1ns / 1ps

module bc12_pixel_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                blk_valid,
    output logic                blk_ready,
    input  bc12_pkg::blk_t      blk,
    output logic                m_valid,
    input  logic                m_ready,
    output bc12_pkg::out_item_t m_data
);

    logic                         busy_reg;
    logic                         busy_next;
    logic [bc12_pkg::PixIdxW-1:0] cnt_reg;
    logic [bc12_pkg::PixIdxW-1:0] cnt_next;
    bc12_pkg::blk_t               blk_reg;
    logic                         ov_reg;
    logic                         ov_next;
    bc12_pkg::out_item_t          out_reg;
    bc12_pkg::out_item_t          pix;

    logic advance;
    logic at_end;
    logic load;
    logic [1:0] s;
    logic [3:0] nib;

    assign advance   = !ov_reg || m_ready;
    assign at_end    = (cnt_reg == bc12_pkg::PixIdxW'(bc12_pkg::PixCount - 1));
    assign blk_ready = !busy_reg || (advance && at_end);
    assign load      = blk_ready && blk_valid;

    assign s   = blk_reg.sel[{cnt_reg, 1'b0} +: 2];
    assign nib = blk_reg.alpha_bits[{cnt_reg, 2'b00} +: 4];

    always_comb begin
        pix.pixel_index = cnt_reg;
        pix.red         = blk_reg.pal[s].r;
        pix.green       = blk_reg.pal[s].g;
        pix.blue        = blk_reg.pal[s].b;
        pix.last        = at_end;
        if (blk_reg.mode) begin
            pix.alpha = {nib, nib};
        end else if (!blk_reg.four && s == bc12_pkg::SelTransp) begin
            pix.alpha = bc12_pkg::AlphaClear;
        end else begin
            pix.alpha = bc12_pkg::AlphaOpaque;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ov_next   = advance ? busy_reg : ov_reg;
        if (busy_reg && advance) begin
            cnt_next = cnt_reg + 1'b1;
            if (at_end) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            blk_reg <= blk;
        end
        if (busy_reg && advance) begin
            out_reg <= pix;
        end
    end

    assign m_valid = ov_reg;
    assign m_data  = out_reg;

endmodule

/* src/bc1_bc2_block_decoder.sv */
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      in_item_t: color_bits, alpha_bits
// m_        out        m_valid / m_ready      out_item_t: pixel_index, rgba, last
// cfg_      in         cfg_valid / cfg_ready  cfg_data: mode
//
// one block in, sixteen pixel transfers out, one per cycle while m_ready is high,
// set by the single pixel sequencer reading the decoded palette
// after the block transfer, the first pixel passes the two palette stages, the
// sequencer load and the output register
// while the sequencer works, the next block is decoded and waits in the palette stages
// m_ready low freezes the output register and the sequencer; nothing is dropped
// aresetn is synchronous, active low; clears valids and sets mode to BC1

module bc1_bc2_block_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bc12_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bc12_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    logic           mode_reg;
    logic           blk_valid;
    logic           blk_ready;
    bc12_pkg::blk_t blk;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    bc12_palette u_palette (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .out_valid (blk_valid),
        .out_ready (blk_ready),
        .out_blk   (blk)
    );

    bc12_pixel_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* src/bc12_checker.sv */
`timescale 1ns / 1ps

module bc12_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bc12_pkg::out_item_t m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // pixels of one block come back to back with rising index
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
            m_valid && m_data.pixel_index == $past(m_data.pixel_index) + 1'b1)
        else $error("pixel burst broken");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.pixel_index == 4'd15)))
        else $error("last mark on wrong pixel");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind bc1_bc2_block_decoder bc12_checker u_bc12_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/bc1_bc2_block_decoder_tb.sv */
`timescale 1ns / 1ps

module bc1_bc2_block_decoder_tb;

    localparam logic ModeBc1 = 1'b0;
    localparam logic ModeBc2 = 1'b1;

    localparam int WatchdogLimit = 2000;
    localparam int DrainPause    = 8;
    localparam int ItemsPerPhase = 48;
    localparam int NumPhases     = 8;
    localparam int HoldOffLen    = 300;

    // per idle kind: none, sender idle, receiver stalling, both
    localparam int SendIdle [4] = '{0, 65, 0, 31};
    localparam int RecvStall[4] = '{0, 0, 65, 31};

    // rgba packs red, green, blue, alpha from the top byte down
    typedef struct packed {
        logic        mode;
        logic [63:0] color;
        logic [63:0] alpha;
        logic        known;
        logic [31:0] rgba;
    } dir_row_t;

    localparam int NumDir = 20;
    localparam dir_row_t DirRows [NumDir] = '{
        // bc1: black, equal endpoints, first entry
        '{ModeBc1, 64'h0000_0000_0000_0000, 64'h0, 1'b1, 32'h000000ff},
        // bc1: equal endpoints and selector 3 give transparent black, alpha half ignored
        '{ModeBc1, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, 32'h00000000},
        '{ModeBc1, 64'h0000_0000_0000_ffff, 64'h0, 1'b1, 32'hffffffff},
        '{ModeBc1, 64'h5555_5555_ffff_0000, 64'h0, 1'b1, 32'hffffffff},
        '{ModeBc1, 64'haaaa_aaaa_0000_ffff, 64'h0, 1'b1, 32'haaaaaaff},
        '{ModeBc1, 64'hffff_ffff_0000_ffff, 64'h0, 1'b1, 32'h555555ff},
        // three-color mean
        '{ModeBc1, 64'haaaa_aaaa_ffff_0000, 64'h0, 1'b1, 32'h7f7f7fff},
        '{ModeBc1, 64'he4e4_e4e4_07e0_f800, 64'h0123_4567_89ab_cdef, 1'b0, 32'h0},
        '{ModeBc1, 64'he4e4_e4e4_f800_07e0, 64'h0, 1'b0, 32'h0},
        '{ModeBc1, 64'h1b1b_1b1b_1234_1234, 64'h0, 1'b0, 32'h0},
        '{ModeBc1, 64'he4e4_e4e4_001f_001f, 64'h0, 1'b0, 32'h0},
        '{ModeBc2, 64'h0000_0000_0000_0000, 64'h0, 1'b1, 32'h00000000},
        '{ModeBc2, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, 32'hffffffff},
        '{ModeBc2, 64'h0000_0000_0000_ffff, 64'h0, 1'b1, 32'hffffff00},
        // bc2 always four colors, even with endpoint0 below endpoint1
        '{ModeBc2, 64'hffff_ffff_ffff_0000, 64'h0, 1'b1, 32'haaaaaa00},
        '{ModeBc2, 64'he4e4_e4e4_07e0_f800, 64'hfedc_ba98_7654_3210, 1'b0, 32'h0},
        '{ModeBc2, 64'h1b1b_1b1b_1234_1234, 64'h0123_4567_89ab_cdef, 1'b0, 32'h0},
        '{ModeBc2, 64'he4e4_e4e4_f800_07e0, 64'h5a5a_a5a5_5a5a_a5a5, 1'b0, 32'h0},
        '{ModeBc1, 64'h0123_4567_8421_8421, 64'hffff_ffff_ffff_ffff, 1'b0, 32'h0},
        '{ModeBc1, 64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 1'b1, 32'h000000ff}
    };

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    bc12_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    bc12_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;

    logic                bc_mode = ModeBc1;
    bc12_pkg::out_item_t pixel_queue[$];
    bc12_pkg::out_item_t pixel_want;
    int                  mismatch_count  = 0;
    int                  quiet_cycles    = 0;
    int                  send_idle_pct   = 0;
    int                  recv_stall_pct  = 0;
    int                  hold_off_cycles = 0;

    bc1_bc2_block_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // expand one block into its sixteen pixels
    function automatic void expand_block(input bc12_pkg::in_item_t blk);
        logic [15:0]         ep [2];
        logic [31:0]         sel;
        int                  pal [4][3];
        logic [7:0]          pal_alpha [4];
        logic                four;
        logic [1:0]          s;
        bc12_pkg::out_item_t px;
        ep[0] = blk.color_bits[15:0];
        ep[1] = blk.color_bits[31:16];
        sel   = blk.color_bits[63:32];
        four  = (bc_mode == ModeBc2) || (ep[0] > ep[1]);
        for (int k = 0; k < 2; k++) begin
            pal[k][0] = {ep[k][15:11], ep[k][15:13]};
            pal[k][1] = {ep[k][10:5], ep[k][10:9]};
            pal[k][2] = {ep[k][4:0], ep[k][4:2]};
        end
        for (int c = 0; c < 3; c++) begin
            if (four) begin
                pal[2][c] = (2 * pal[0][c] + pal[1][c]) / 3;
                pal[3][c] = (pal[0][c] + 2 * pal[1][c]) / 3;
            end else begin
                pal[2][c] = (pal[0][c] + pal[1][c]) / 2;
                pal[3][c] = 0;
            end
        end
        pal_alpha[0] = bc12_pkg::AlphaOpaque;
        pal_alpha[1] = bc12_pkg::AlphaOpaque;
        pal_alpha[2] = bc12_pkg::AlphaOpaque;
        pal_alpha[3] = four ? bc12_pkg::AlphaOpaque : bc12_pkg::AlphaClear;
        for (int p = 0; p < bc12_pkg::PixCount; p++) begin
            s = sel[2*p +: 2];
            px.pixel_index = 4'(p);
            px.red   = 8'(pal[s][0]);
            px.green = 8'(pal[s][1]);
            px.blue  = 8'(pal[s][2]);
            if (bc_mode == ModeBc2)
                px.alpha = 8'(blk.alpha_bits[4*p +: 4] * 17);
            else
                px.alpha = pal_alpha[s];
            px.last = (p == bc12_pkg::PixCount - 1);
            pixel_queue.push_back(px);
        end
    endfunction

    function automatic bc12_pkg::in_item_t make_block();
        bc12_pkg::in_item_t blk;
        blk.color_bits = {$urandom, $urandom};
        blk.alpha_bits = {$urandom, $urandom};
        case ($urandom_range(7))
            0: blk.color_bits[31:16] = blk.color_bits[15:0];
            1: begin
                blk.color_bits[15:0]  = $urandom_range(1) ? 16'hffff : 16'h0000;
                blk.color_bits[31:16] = $urandom_range(1) ? 16'hffff : 16'h0000;
            end
            2: blk.color_bits[63:32] = {16{blk.color_bits[33:32]}};
            default: ;
        endcase
        return blk;
    endfunction

    // known rows carry one color for all sixteen pixels
    task automatic send_block(input bc12_pkg::in_item_t blk, input logic known,
                              input logic [31:0] rgba);
        bc12_pkg::out_item_t px;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= blk;
        do @(posedge aclk); while (!s_ready);
        if (known) begin
            for (int p = 0; p < bc12_pkg::PixCount; p++) begin
                px.pixel_index = 4'(p);
                {px.red, px.green, px.blue, px.alpha} = rgba;
                px.last = (p == bc12_pkg::PixCount - 1);
                pixel_queue.push_back(px);
            end
        end else begin
            expand_block(blk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge aclk);
        repeat (DrainPause) @(posedge aclk);
    endtask

    task automatic write_mode(input logic value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        bc_mode = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pixel_queue.size() == 0) begin
                $display("%0t: unexpected pixel transfer %p", $time, m_data);
                mismatch_count++;
            end else begin
                pixel_want = pixel_queue.pop_front();
                check_field("pixel_index", pixel_want.pixel_index, m_data.pixel_index);
                check_field("red", pixel_want.red, m_data.red);
                check_field("green", pixel_want.green, m_data.green);
                check_field("blue", pixel_want.blue, m_data.blue);
                check_field("alpha", pixel_want.alpha, m_data.alpha);
                check_field("last", pixel_want.last, m_data.last);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // first rows run on the reset mode
        for (int i = 0; i < NumDir; i++) begin
            if (DirRows[i].mode != bc_mode) begin
                settle();
                write_mode(DirRows[i].mode);
            end
            send_block({DirRows[i].color, DirRows[i].alpha}, DirRows[i].known, DirRows[i].rgba);
        end

        for (int ph = 0; ph < NumPhases; ph++) begin
            settle();
            write_mode(ph[0] ? ModeBc2 : ModeBc1);
            send_idle_pct  = SendIdle[ph / 2];
            recv_stall_pct = RecvStall[ph / 2];
            if (ph == 1)
                hold_off_cycles = HoldOffLen;
            repeat (ItemsPerPhase) send_block(make_block(), 1'b0, '0);
        end

        settle();
        repeat (bc12_pkg::PixCount) @(posedge aclk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
src/bc12_pkg.sv
src/bc12_palette.sv
src/bc12_pixel_seq.sv
src/bc1_bc2_block_decoder.sv
src/bc12_checker.sv
tb/bc1_bc2_block_decoder_tb.sv
